>>> hw/rtl/npd_pkg.sv
// shared types and constants for the nearest point distance block
`default_nettype none

package npd_pkg;

  // coordinate width of the stored points and query positions
  localparam int COORD_BITS = 16;
  // squared component difference, sum of three squares, root width
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int SUM_W  = SQ_W + 2;
  localparam int DIST_W = SUM_W / 2;
  // root remainder, shifted remainder and step counter widths
  localparam int REM_W  = DIST_W + 1;
  localparam int SH_W   = REM_W + 2;
  localparam int STEP_W = $clog2(DIST_W);

  // item kinds
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  typedef struct packed {
    logic        [1:0]            kind;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
  } npd_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              no_points;
  } npd_out_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } npd_point_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic append;
    logic query;
    logic issue;
    logic sqrt_start;
    logic load_out;
  } npd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic count_zero;
    logic issue_last;
    logic pipe_busy;
    logic sqrt_busy;
    logic out_free;
  } npd_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/npd_isqrt.sv
// iterative floor square root, one result bit per cycle
`default_nettype none

module npd_isqrt
  import npd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [SUM_W-1:0]  radicand_i,
  output logic                   busy_o,
  output logic [DIST_W-1:0]      root_o
);

  logic              busy_q;
  logic [STEP_W-1:0] cnt_q;
  logic [SUM_W-1:0]  val_q;
  logic [REM_W-1:0]  rem_q;
  logic [DIST_W-1:0] root_q;

  logic [SH_W-1:0]   rem_sh;
  logic [SH_W-1:0]   trial;
  logic              ge;
  logic [SH_W-1:0]   rem_diff;
  logic [REM_W-1:0]  rem_d;
  logic [DIST_W-1:0] root_d;

  // bring down the next two radicand bits and try a one in the root
  always_comb begin
    rem_sh   = {rem_q, val_q[SUM_W-1 -: 2]};
    trial    = {1'b0, root_q, 2'b01};
    ge       = (rem_sh >= trial);
    rem_diff = rem_sh - trial;
    rem_d    = ge ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
    root_d   = {root_q[DIST_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + STEP_W'(1);
      if (cnt_q == STEP_W'(DIST_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q  <= {val_q[SUM_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

>>> hw/rtl/npd_dp.sv
// datapath: point memory, distance pipeline, running minimum, root and output register
`default_nettype none

module npd_dp
  import npd_pkg::*;
#(
  parameter int MAX_POINTS = 1024
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire npd_in_t  in_data_i,
  input  wire npd_cmd_t cmd_i,
  output npd_status_t   status_o,
  input  wire logic     out_stall_i,
  output logic          out_valid_o,
  output npd_out_t      out_data_o
);

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  npd_point_t mem [MAX_POINTS];

  npd_point_t        in_pt;
  logic [CW-1:0]     count_q;
  logic [CW-1:0]     idx_q;
  logic [CW-1:0]     idx_inc;
  logic              empty_q;
  logic              first_q;
  npd_point_t        qry_q;
  npd_point_t        rd_q;
  logic              v0_q, v1_q, v2_q, v3_q;
  logic [COORD_BITS-1:0] mag_x_q, mag_y_q, mag_z_q;
  logic [COORD_BITS-1:0] mag_x, mag_y, mag_z;
  logic [SQ_W-1:0]   sq_x_q, sq_y_q, sq_z_q;
  logic [SUM_W-1:0]  sum_q;
  logic [SUM_W-1:0]  best_q;
  logic              sqrt_busy;
  logic [DIST_W-1:0] root;
  logic              out_valid_q;
  npd_out_t          out_q;
  logic              out_free;
  logic              can_store;

  function automatic logic [COORD_BITS-1:0] abs_diff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic signed [COORD_BITS:0] d;
    logic        [COORD_BITS:0] m;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    m = d[COORD_BITS] ? (~d + 1'b1) : d;
    return m[COORD_BITS-1:0];
  endfunction

  assign in_pt     = '{x: in_data_i.coord_x, y: in_data_i.coord_y, z: in_data_i.coord_z};
  assign idx_inc   = idx_q + CW'(1);
  assign can_store = (count_q < CW'(MAX_POINTS));
  assign out_free  = !out_valid_q || !out_stall_i;

  // store and scan control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      first_q <= 1'b0;
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        count_q <= '0;
      end else if (cmd_i.append && can_store) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.query) begin
        idx_q   <= '0;
        first_q <= 1'b1;
      end else begin
        if (cmd_i.issue) begin
          idx_q <= idx_inc;
        end
        if (v3_q) begin
          first_q <= 1'b0;
        end
      end
      v0_q <= cmd_i.issue;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append && can_store) begin
      mem[count_q[AW-1:0]] <= in_pt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      rd_q <= mem[idx_q[AW-1:0]];
    end
  end

  always_comb begin
    mag_x = abs_diff(qry_q.x, rd_q.x);
    mag_y = abs_diff(qry_q.y, rd_q.y);
    mag_z = abs_diff(qry_q.z, rd_q.z);
  end

  // distance pipeline and running minimum
  always_ff @(posedge clk_i) begin
    if (cmd_i.query) begin
      qry_q   <= in_pt;
      empty_q <= (count_q == '0);
    end
    mag_x_q <= mag_x;
    mag_y_q <= mag_y;
    mag_z_q <= mag_z;
    sq_x_q  <= mag_x_q * mag_x_q;
    sq_y_q  <= mag_y_q * mag_y_q;
    sq_z_q  <= mag_z_q * mag_z_q;
    sum_q   <= SUM_W'(sq_x_q) + SUM_W'(sq_y_q) + SUM_W'(sq_z_q);
    if (v3_q && (first_q || (sum_q < best_q))) begin
      best_q <= sum_q;
    end
  end

  npd_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sqrt_start),
    .radicand_i (best_q),
    .busy_o     (sqrt_busy),
    .root_o     (root)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.distance  <= empty_q ? '1 : root;
      out_q.no_points <= empty_q;
    end
  end

  assign status_o.count_zero = (count_q == '0);
  assign status_o.issue_last = (idx_inc == count_q);
  assign status_o.pipe_busy  = v0_q || v1_q || v2_q || v3_q;
  assign status_o.sqrt_busy  = sqrt_busy;
  assign status_o.out_free   = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/npd_ctrl.sv
// controller state machine: decodes items and sequences scan, root and result
`default_nettype none

module npd_ctrl
  import npd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic [1:0]  in_kind_i,
  output logic             in_stall_o,
  input  wire npd_status_t status_i,
  output npd_cmd_t         cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_SQRT  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_kind_i)
            KIND_CLEAR:  cmd_o.clear  = 1'b1;
            KIND_APPEND: cmd_o.append = 1'b1;
            KIND_QUERY: begin
              cmd_o.query = 1'b1;
              state_d     = status_i.count_zero ? ST_DONE : ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (status_i.issue_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait for the last point to reach the running minimum
        if (!status_i.pipe_busy) begin
          cmd_o.sqrt_start = 1'b1;
          state_d          = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (!status_i.sqrt_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

>>> hw/rtl/nearest_point_distance_top.sv
// top level of the nearest point distance block
`default_nettype none

// Keeps up to MAX_POINTS signed Q8.8 3D points. A clear or append item leaves
// the block idle and ready for the next item. A query reads the stored points
// from the point memory, one point per cycle, through a four-stage read,
// difference, square and sum pipeline into a running minimum, then takes the
// floor square root of that squared distance, one root bit per cycle. A query
// on an empty store returns all ones and no_points. Appends to a full store
// are dropped. The result sits in an output register, so clear and append
// items are still taken while it waits to be collected.
module nearest_point_distance_top
  import npd_pkg::*;
#(
  parameter int MAX_POINTS = 1024
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire npd_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output npd_out_t     out_data_o
);

  npd_cmd_t    cmd;
  npd_status_t status;

  npd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_data_i.kind),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  npd_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
